@@ hdl/sde3_pkg.sv @@
// Shared constants, types and helpers for the 3x3 symbol dilate/erode block.
// No dependencies; used by hdl/symbol_dilate_erode_3x3.sv.
package sde3_pkg;

	// symbol and line memory geometry
	localparam int SYM_W  = 8;
	localparam int SLOTS  = 4;
	localparam int SLOT_W = 2;
	localparam int WORD_W = SYM_W * SLOTS;

	// default image limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// configuration port
	localparam int SIZE_W      = 11;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REPLACE   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EIGHT     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT    = 3'd5;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// input beat kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// operating modes
	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;

	// control carried from the read-issue cycle to the window stage
	typedef struct packed {
		logic              top_in;
		logic              bot_in;
		logic              left_in;
		logic              right_in;
		logic [SLOT_W-1:0] slot;
		logic              fwd_a;
		logic              fwd_b;
		logic [SLOT_W-1:0] fwd_slot;
		logic [SYM_W-1:0]  fwd_pix;
		logic              row_end;
		logic              frame_end;
	} s1_ctrl_t;

	// pick one row slot out of a column word
	function automatic logic [SYM_W-1:0] slot_byte(input logic [WORD_W-1:0] word,
			input logic [SLOT_W-1:0] idx);
		slot_byte = word[SYM_W*idx +: SYM_W];
	endfunction

	// replace one row slot of a column word when a same-cycle write hit it
	function automatic logic [WORD_W-1:0] patch_word(input logic [WORD_W-1:0] word,
			input logic hit, input logic [SLOT_W-1:0] idx, input logic [SYM_W-1:0] pix);
		logic [WORD_W-1:0] res;
		res = word;
		if (hit) begin
			res[SYM_W*idx +: SYM_W] = pix;
		end
		patch_word = res;
	endfunction

endpackage

@@ hdl/sde3_ram.sv @@
// Generic simple RAM: one bit-masked write port, two registered read ports.
// No dependencies; used as the line memory of the dilate/erode block.
module sde3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [WIDTH-1:0]         wr_mask,
	input  logic                     rd_en_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic                     rd_en_b,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// masked write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wr_mask[i]) begin
					mem[wr_addr][i] <= wr_data[i];
				end
			end
		end
	end

	// registered reads, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en_a) begin
			rd_data_a <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

@@ hdl/symbol_dilate_erode_3x3.sv @@
// Top level of the 3x3 symbol dilate/erode block: counters, line memory, window, output.
// Depends on hdl/sde3_pkg.sv and hdl/sde3_ram.sv.
//
// Takes one beat per clock, sustained, in both directions: a pixel or flush beat is
// accepted whenever the window stage is empty or the output register is free or being
// taken. Each result leaves one row and one pixel (width + 1 pixel beats) after its own
// pixel; flush beats drain the tail of a finished frame, and pixels of a new frame push
// out the old one. The line memory holds one word per column with four row slots; each
// pixel is a masked write, and each result reads its centre and right columns through
// the memory's two read ports (only the centre at a row end), the left column being the
// previous centre. A result enters the window stage on the edge that accepts the
// beat releasing it and is loaded into the output register once that register is free
// or being taken. The memory is not cleared after reset.
// Writing image_width or image_height restarts the stream.
module symbol_dilate_erode_3x3 #(
	parameter int MAX_WIDTH  = sde3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sde3_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sde3_pkg::SYM_W-1:0]       s_tdata,   // [7:0] pixel_in
	input  logic                             s_tuser,   // [0] req_type
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sde3_pkg::SYM_W-1:0]       m_tdata,   // [7:0] pixel_out
	output logic                             m_tuser,   // [0] row_end
	output logic                             m_tlast,   // frame_end
	// configuration
	input  logic                             cfg_we,
	input  logic [sde3_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sde3_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import sde3_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int LW  = $clog2(MAX_WIDTH + 3);
	localparam int CMW = WW + 1;
	localparam int WCW = (WW > SIZE_W) ? WW : SIZE_W;
	localparam int HCW = (HW > SIZE_W) ? HW : SIZE_W;

	// configuration registers
	logic              mode_q;
	logic [SYM_W-1:0]  target_q;
	logic [SYM_W-1:0]  replace_q;
	logic              eight_q;
	logic [SIZE_W-1:0] width_cfg_q;
	logic [SIZE_W-1:0] height_cfg_q;
	logic              restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_DILATE;
			target_q     <= '0;
			replace_q    <= '0;
			eight_q      <= 1'b0;
			width_cfg_q  <= SIZE_RESET;
			height_cfg_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:    mode_q       <= cfg_data[0];
				REG_TARGET:  target_q     <= cfg_data[SYM_W-1:0];
				REG_REPLACE: replace_q    <= cfg_data[SYM_W-1:0];
				REG_EIGHT:   eight_q      <= cfg_data[0];
				REG_WIDTH:   width_cfg_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:  height_cfg_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	// image size saturated to the supported range
	logic [WCW-1:0] width_raw, width_sat;
	logic [HCW-1:0] height_raw, height_sat;
	logic [WW-1:0]  w;
	logic [HW-1:0]  h;

	always_comb begin
		width_raw  = WCW'(width_cfg_q);
		height_raw = HCW'(height_cfg_q);
		if (width_raw < WCW'(2)) begin
			width_sat = WCW'(2);
		end else if (width_raw > WCW'(MAX_WIDTH)) begin
			width_sat = WCW'(MAX_WIDTH);
		end else begin
			width_sat = width_raw;
		end
		if (height_raw < HCW'(2)) begin
			height_sat = HCW'(2);
		end else if (height_raw > HCW'(MAX_HEIGHT)) begin
			height_sat = HCW'(MAX_HEIGHT);
		end else begin
			height_sat = height_raw;
		end
		w = width_sat[WW-1:0];
		h = height_sat[HW-1:0];
	end

	// stream position state
	logic [CW-1:0]     in_col_q, out_col_q;
	logic [RW-1:0]     in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [LW-1:0]     lag_q;

	// handshake and pipeline state
	logic     s1_valid_q;
	s1_ctrl_t s1_ctrl_s1;
	logic     m_valid_q;
	logic     out_free;
	logic     accept;
	logic     is_pixel;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !s1_valid_q || out_free;
	assign accept   = s_tvalid && s_tready;
	assign is_pixel = (s_tuser == REQ_PIXEL);

	// emit decision for the accepted beat
	logic [LW-1:0]  lag_inc;
	logic           in_col_last, out_col_last, out_row_last, out_row_penult;
	logic           near_end;
	logic [CMW-1:0] remaining;
	logic           emit, fire;
	logic [CW-1:0]  out_col_next;

	always_comb begin
		lag_inc        = lag_q + LW'(is_pixel);
		in_col_last    = (WW'(in_col_q) + WW'(1)) == w;
		out_col_last   = (WW'(out_col_q) + WW'(1)) == w;
		out_row_last   = (HW'(out_row_q) + HW'(1)) == h;
		out_row_penult = (HW'(out_row_q) + HW'(2)) == h;
		near_end       = out_row_last || out_row_penult;
		// only the last two rows can be within reach of the pending count
		if (out_row_last) begin
			remaining = CMW'(w) - CMW'(out_col_q);
		end else begin
			remaining = (CMW'(w) << 1) - CMW'(out_col_q);
		end
		emit = (lag_inc != '0) &&
			((near_end && (CMW'(lag_inc) >= remaining)) ||
			 (is_pixel && (CMW'(lag_inc) > (CMW'(w) + CMW'(1)))));
		fire         = accept && emit;
		out_col_next = out_col_q + CW'(1);
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			lag_q      <= '0;
		end else if (restart) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			lag_q      <= '0;
		end else if (accept) begin
			lag_q <= lag_inc - LW'(fire);
			if (is_pixel) begin
				if (in_col_last) begin
					in_col_q  <= '0;
					in_slot_q <= in_slot_q + SLOT_W'(1);
					if ((HW'(in_row_q) + HW'(1)) == h) begin
						in_row_q <= '0;
					end else begin
						in_row_q <= in_row_q + RW'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (fire) begin
				if (out_col_last) begin
					out_col_q  <= '0;
					out_slot_q <= out_slot_q + SLOT_W'(1);
					if (out_row_last) begin
						out_row_q <= '0;
					end else begin
						out_row_q <= out_row_q + RW'(1);
					end
				end else begin
					out_col_q <= out_col_next;
				end
			end
		end
	end

	// line memory: one word per column, one byte per row slot
	logic              mem_we;
	logic [WORD_W-1:0] mem_wdata, mem_wmask;
	logic              rd_en_a, rd_en_b;
	logic [WORD_W-1:0] rd_data_a, rd_data_b;

	assign mem_we    = accept && is_pixel;
	assign mem_wdata = {SLOTS{s_tdata}};
	assign mem_wmask = WORD_W'({SYM_W{1'b1}}) << (SYM_W * in_slot_q);
	assign rd_en_a   = fire && !out_col_last;
	assign rd_en_b   = fire;

	sde3_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_line_mem (
		.clk       (clk),
		.wr_en     (mem_we),
		.wr_addr   (in_col_q),
		.wr_data   (mem_wdata),
		.wr_mask   (mem_wmask),
		.rd_en_a   (rd_en_a),
		.rd_addr_a (out_col_next),
		.rd_data_a (rd_data_a),
		.rd_en_b   (rd_en_b),
		.rd_addr_b (out_col_q),
		.rd_data_b (rd_data_b)
	);

	// control for the window stage, with forwarding of the same-cycle pixel write
	always_ff @(posedge clk) begin
		if (fire) begin
			s1_ctrl_s1.top_in    <= (out_row_q != '0);
			s1_ctrl_s1.bot_in    <= !out_row_last;
			s1_ctrl_s1.left_in   <= (out_col_q != '0);
			s1_ctrl_s1.right_in  <= !out_col_last;
			s1_ctrl_s1.slot      <= out_slot_q;
			s1_ctrl_s1.fwd_a     <= is_pixel && (in_col_q == out_col_next);
			s1_ctrl_s1.fwd_b     <= is_pixel && (in_col_q == out_col_q);
			s1_ctrl_s1.fwd_slot  <= in_slot_q;
			s1_ctrl_s1.fwd_pix   <= s_tdata;
			s1_ctrl_s1.row_end   <= out_col_last;
			s1_ctrl_s1.frame_end <= out_row_last && out_col_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (fire) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	// window assembly and decision
	logic [WORD_W-1:0] col_left_q;
	logic [WORD_W-1:0] col_mid, col_right;
	logic [SLOT_W-1:0] slot_up, slot_dn;
	logic [SYM_W-1:0]  nb_val [8];
	logic [7:0]        nb_use;
	logic [SYM_W-1:0]  center, result;
	logic              hit;
	logic              s1_move;

	assign s1_move = s1_valid_q && out_free;

	always_comb begin
		col_mid   = patch_word(rd_data_b, s1_ctrl_s1.fwd_b, s1_ctrl_s1.fwd_slot,
			s1_ctrl_s1.fwd_pix);
		col_right = patch_word(rd_data_a, s1_ctrl_s1.fwd_a, s1_ctrl_s1.fwd_slot,
			s1_ctrl_s1.fwd_pix);
		slot_up   = s1_ctrl_s1.slot - SLOT_W'(1);
		slot_dn   = s1_ctrl_s1.slot + SLOT_W'(1);
		center    = slot_byte(col_mid, s1_ctrl_s1.slot);

		// neighbours: up-left, up, up-right, left, right, down-left, down, down-right
		nb_val[0] = slot_byte(col_left_q, slot_up);
		nb_val[1] = slot_byte(col_mid, slot_up);
		nb_val[2] = slot_byte(col_right, slot_up);
		nb_val[3] = slot_byte(col_left_q, s1_ctrl_s1.slot);
		nb_val[4] = slot_byte(col_right, s1_ctrl_s1.slot);
		nb_val[5] = slot_byte(col_left_q, slot_dn);
		nb_val[6] = slot_byte(col_mid, slot_dn);
		nb_val[7] = slot_byte(col_right, slot_dn);

		nb_use[0] = eight_q && s1_ctrl_s1.top_in && s1_ctrl_s1.left_in;
		nb_use[1] = s1_ctrl_s1.top_in;
		nb_use[2] = eight_q && s1_ctrl_s1.top_in && s1_ctrl_s1.right_in;
		nb_use[3] = s1_ctrl_s1.left_in;
		nb_use[4] = s1_ctrl_s1.right_in;
		nb_use[5] = eight_q && s1_ctrl_s1.bot_in && s1_ctrl_s1.left_in;
		nb_use[6] = s1_ctrl_s1.bot_in;
		nb_use[7] = eight_q && s1_ctrl_s1.bot_in && s1_ctrl_s1.right_in;

		// dilate looks for the target, erode for anything else
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (nb_use[i] && ((nb_val[i] == target_q) != (mode_q == MODE_ERODE))) begin
				hit = 1'b1;
			end
		end

		result = center;
		if (mode_q == MODE_DILATE) begin
			if (center != target_q && hit) begin
				result = target_q;
			end
		end else begin
			if (center == target_q && hit) begin
				result = replace_q;
			end
		end
	end

	// the centre column becomes the next result's left column
	always_ff @(posedge clk) begin
		if (s1_move) begin
			col_left_q <= col_mid;
		end
	end

	// output register
	logic [SYM_W-1:0] m_pixel_q;
	logic             m_row_end_q, m_frame_end_q;

	always_ff @(posedge clk) begin
		if (s1_move) begin
			m_pixel_q     <= result;
			m_row_end_q   <= s1_ctrl_s1.row_end;
			m_frame_end_q <= s1_ctrl_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_move) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_pixel_q;
	assign m_tuser  = m_row_end_q;
	assign m_tlast  = m_frame_end_q;

endmodule

@@ tb/tb_symbol_dilate_erode_3x3.sv @@
// Self-checking testbench for symbol_dilate_erode_3x3: streams raster images through the
// block and checks every output beat against a built-in raster and window predictor.
// Depends on hdl/sde3_pkg.sv and hdl/symbol_dilate_erode_3x3.sv.
module tb_symbol_dilate_erode_3x3;
	timeunit 1ns;
	timeprecision 1ps;

	import sde3_pkg::*;

	localparam int MAX_W         = DEF_MAX_WIDTH;
	localparam int MAX_H         = DEF_MAX_HEIGHT;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	// watchdog limit, set well above the slowest correct run
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct packed {
		logic             req;
		logic [SYM_W-1:0] pix;
	} in_beat_t;

	typedef struct packed {
		logic [SYM_W-1:0] pix;
		logic             row_end;
		logic             frame_end;
	} out_px_t;

	// dut ports
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [SYM_W-1:0]       s_tdata = '0;    // [7:0] pixel_in
	logic                   s_tuser = 1'b0;  // [0] req_type
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [SYM_W-1:0]       m_tdata;         // [7:0] pixel_out
	logic                   m_tuser;         // [0] row_end
	logic                   m_tlast;         // frame_end
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	symbol_dilate_erode_3x3 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// stimulus and expected output
	in_beat_t beat_q[$];
	out_px_t  expected_px[$];
	int       mismatches = 0;
	int       tx_idle_pct = 0;
	int       rx_stall_pct = 0;
	int       hold_requests = 0;
	int       pixels_queued = 0;

	// predictor copy of the registers
	logic              cfg_mode = MODE_DILATE;
	logic [SYM_W-1:0]  cfg_target = '0;
	logic [SYM_W-1:0]  cfg_replace = '0;
	logic              cfg_eight = 1'b0;
	logic [SIZE_W-1:0] cfg_w = SIZE_RESET;
	logic [SIZE_W-1:0] cfg_h = SIZE_RESET;

	// predictor raster state: four row slots, input and output positions
	logic [SYM_W-1:0] line_mem [4*MAX_W];
	int in_col = 0, in_row = 0, in_slot = 0;
	int out_col = 0, out_row = 0, out_slot = 0;
	int lag = 0;

	// generator view of the current geometry and symbols
	int               gen_w = MAX_W;
	int               gen_area = MAX_W * MAX_H;
	int               gen_pos = 0;
	int               sym_density = 30;
	logic [SYM_W-1:0] gen_target = '0;
	logic [SYM_W-1:0] gen_alt = 8'h2e;

	function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int maxv);
		if (v < 2) return 2;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	task automatic restart_raster();
		in_col = 0; in_row = 0; in_slot = 0;
		out_col = 0; out_row = 0; out_slot = 0;
		lag = 0;
	endtask

	// one accepted beat: store the pixel, then produce the window result if one is due
	task automatic morph_step(input logic req, input logic [SYM_W-1:0] pix);
		int w, h, remaining, r, c, slot;
		logic [SYM_W-1:0] v, center;
		logic hit, in_img, used;
		out_px_t res;
		w = clamp_dim(cfg_w, MAX_W);
		h = clamp_dim(cfg_h, MAX_H);
		hit = 1'b0;
		if (req == REQ_PIXEL) begin
			line_mem[in_slot*MAX_W + in_col] = pix;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_slot = (in_slot + 1) % 4;
				in_row++;
				if (in_row >= h) in_row = 0;
			end
			lag++;
		end
		remaining = w*h - (out_row*w + out_col);
		if (!(lag > 0 && (lag >= remaining || (req == REQ_PIXEL && lag > w + 1)))) return;
		center = line_mem[out_slot*MAX_W + out_col];
		// scan the neighborhood, ignoring positions outside the image
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				r = out_row + dr;
				c = out_col + dc;
				in_img = r >= 0 && r < h && c >= 0 && c < w;
				used = ((dr == 0) != (dc == 0)) || (dr != 0 && cfg_eight);
				if (in_img && used) begin
					slot = (out_slot + dr + 4) % 4;
					v = line_mem[slot*MAX_W + c];
					if (cfg_mode == MODE_DILATE) begin
						if (v == cfg_target) hit = 1'b1;
					end else begin
						if (v != cfg_target) hit = 1'b1;
					end
				end
			end
		end
		if (cfg_mode == MODE_DILATE) begin
			if (center != cfg_target && hit) center = cfg_target;
		end else begin
			if (center == cfg_target && hit) center = cfg_replace;
		end
		res.pix = center;
		res.row_end = (out_col == w - 1);
		res.frame_end = (remaining == 1);
		expected_px.insert(expected_px.size(), res);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_slot = (out_slot + 1) % 4;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
		lag--;
	endtask

	// driver: hold a beat until taken, then load the next one or idle
	in_beat_t beat_next;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) morph_step(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (beat_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					beat_next = beat_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= beat_next.pix;
					s_tuser  <= beat_next.req;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each output beat, drive ready with random and long stalls
	out_px_t px_want;
	int      hold_served = 0;
	int      hold_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_px.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got pixel_out=%h row_end=%b frame_end=%b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					px_want = expected_px.pop_front();
					if (m_tdata !== px_want.pix) begin
						$display("%0t: pixel_out expected %h got %h", $time, px_want.pix, m_tdata);
						mismatches++;
					end
					if (m_tuser !== px_want.row_end) begin
						$display("%0t: row_end expected %b got %b", $time, px_want.row_end, m_tuser);
						mismatches++;
					end
					if (m_tlast !== px_want.frame_end) begin
						$display("%0t: frame_end expected %b got %b",
							$time, px_want.frame_end, m_tlast);
						mismatches++;
					end
				end
			end
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// watchdog
	int cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_symbol_dilate_erode_3x3: FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (beat_q.size() != 0 || s_tvalid || expected_px.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, mirrored into the predictor on the edge it lands
	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:    cfg_mode = val[0];
			REG_TARGET:  cfg_target = val[SYM_W-1:0];
			REG_REPLACE: cfg_replace = val[SYM_W-1:0];
			REG_EIGHT:   cfg_eight = val[0];
			REG_WIDTH:   begin cfg_w = val; restart_raster(); end
			REG_HEIGHT:  begin cfg_h = val; restart_raster(); end
			default:     ;
		endcase
	endtask

	// pause the stream until idle, then write every register
	task automatic apply_config(input logic [CFG_DATA_W-1:0] mode_v, tgt_v, rep_v, eight_v,
			w_v, h_v);
		wait_drained();
		write_cfg(REG_MODE, mode_v);
		write_cfg(REG_TARGET, tgt_v);
		write_cfg(REG_REPLACE, rep_v);
		write_cfg(REG_EIGHT, eight_v);
		write_cfg(REG_WIDTH, w_v);
		write_cfg(REG_HEIGHT, h_v);
		gen_w = clamp_dim(w_v, MAX_W);
		gen_area = gen_w * clamp_dim(h_v, MAX_H);
		gen_pos = 0;
		gen_target = tgt_v[SYM_W-1:0];
	endtask

	task automatic push_px(input logic [SYM_W-1:0] pix);
		beat_q.insert(beat_q.size(), '{req: REQ_PIXEL, pix: pix});
		gen_pos = (gen_pos + 1) % gen_area;
		pixels_queued++;
	endtask

	task automatic push_flush();
		beat_q.insert(beat_q.size(), '{req: REQ_FLUSH, pix: SYM_W'($urandom_range(0, 255))});
	endtask

	function automatic logic [SYM_W-1:0] rand_pixel();
		if ($urandom_range(0, 99) < sym_density) return gen_target;
		if ($urandom_range(0, 2) == 0) return SYM_W'($urandom_range(0, 255));
		return gen_alt;
	endfunction

	// complete the current frame and drain its tail
	task automatic finish_frame();
		repeat ((gen_area - gen_pos) % gen_area) push_px(rand_pixel());
		repeat (gen_w + 1) push_flush();
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return SYM_W'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly small sizes, now and then too small or wider
	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 19))
			0:       return SIZE_W'($urandom_range(0, 1));
			1:       return SIZE_W'($urandom_range(12, 40));
			default: return SIZE_W'($urandom_range(2, 8));
		endcase
	endfunction

	// one stretch of random traffic, mostly whole frames
	task automatic push_run();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				repeat (gen_area - gen_pos) push_px(rand_pixel());
				if ($urandom_range(0, 2) != 0) repeat (gen_w + 1 + $urandom_range(0, 2)) push_flush();
			end
			6, 7: begin
				repeat ($urandom_range(1, gen_area - 1)) push_px(rand_pixel());
				repeat ($urandom_range(1, 2)) push_flush();
			end
			8: repeat ($urandom_range(1, 3)) push_flush();
			default: begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 1) == 0) push_px(SYM_W'($urandom_range(0, 255)));
					else push_flush();
				end
			end
		endcase
	endtask

	initial begin
		int seg;
		int base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: a few results from a 1024-wide frame, then a size write drops the rest
		repeat (MAX_W + 6) push_px(rand_pixel());

		// dilate, four neighbors, with a flush mid-frame and one with nothing pending
		apply_config(CFG_DATA_W'(MODE_DILATE), 11'h0ff, 11'h000, 11'h000, 11'd3, 11'd3);
		push_px(8'h00); push_px(8'hff); push_px(8'h00); push_px(8'h00);
		push_flush();
		push_px(8'h00); push_px(8'h00); push_px(8'h80); push_px(8'h00); push_px(8'h7f);
		finish_frame();
		push_flush();

		// erode, eight neighbors, undersized geometry, two frames back to back
		apply_config(11'h7fe | CFG_DATA_W'(MODE_ERODE), 11'h700, 11'h0ff, 11'h7ff, 11'd1,
			11'd0);
		push_px(8'h00); push_px(8'h00); push_px(8'h00); push_px(8'h55);
		push_px(8'hff); push_px(8'h00); push_px(8'h00); push_px(8'h00);
		finish_frame();

		// oversized geometry, once per dimension
		apply_config(CFG_DATA_W'(MODE_DILATE), 11'h041, 11'h000, 11'h001, 11'd2047, 11'd1);
		finish_frame();
		apply_config(CFG_DATA_W'(MODE_ERODE), 11'h041, 11'h0aa, 11'h000, 11'd2, 11'd1100);
		sym_density = 85;
		finish_frame();

		// long receiver hold while the sender keeps streaming
		apply_config(CFG_DATA_W'(MODE_DILATE), 11'h023, 11'h000, 11'h000, 11'd4, 11'd6);
		sym_density = 30;
		hold_requests++;
		repeat (3) repeat (gen_area) push_px(rand_pixel());
		finish_frame();

		// random segments through the idling phases
		base = pixels_queued;
		seg = 0;
		while (pixels_queued - base < 2000) begin
			apply_config(SIZE_W'($urandom_range(0, 2047)), {3'($urandom_range(0, 7)), pick_symbol()},
				{3'($urandom_range(0, 7)), pick_symbol()}, SIZE_W'($urandom_range(0, 2047)),
				pick_size(), pick_size());
			gen_alt = pick_symbol();
			case ($urandom_range(0, 2))
				0:       sym_density = 10;
				1:       sym_density = 50;
				default: sym_density = 85;
			endcase
			case (seg % 4)
				0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1:       begin tx_idle_pct = 69; rx_stall_pct = 0;  end
				2:       begin tx_idle_pct = 0;  rx_stall_pct = 69; end
				default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
			endcase
			repeat ($urandom_range(3, 8)) push_run();
			finish_frame();
			seg++;
		end

		wait_drained();
		if (mismatches == 0) $display("tb_symbol_dilate_erode_3x3: PASS");
		else $display("tb_symbol_dilate_erode_3x3: FAIL");
		$finish;
	end

endmodule
